### rtl/hdt_pkg.sv
package hdt_pkg;

  localparam int SLOTS     = 64;
  localparam int SIZE_BITS = 20;
  localparam int SLOT_W    = 6;           // policy slot number field
  localparam int PTR_W     = SLOT_W + 1;  // slot number or the none marker
  localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(SLOTS);

  localparam int KIND_W   = 2;
  localparam int CLASS_W  = 2;
  localparam int SIDX_W   = 8;
  localparam int STATUS_W = 3;
  localparam int TIDX_W   = 9;
  localparam int CNT_W    = 7;
  localparam int STATC_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_W       = STATUS_W + 1 + TIDX_W + 1 + SIZE_BITS + CNT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACTIVATE = 2'd0,
    KIND_RESOLVE  = 2'd1,
    KIND_RESIZE   = 2'd2,
    KIND_ACK      = 2'd3
  } kind_t;

  localparam logic [CLASS_W-1:0] CLS_STATIC = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_POLICY = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_STATIC  = 3'd2,
    ST_ALREADY = 3'd3,
    ST_REJECT  = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT   = 2'd2;

  localparam logic [CNT_W-1:0]     RST_SLOTS  = 7'd64;
  localparam logic [STATC_W-1:0]   RST_STATIC = 8'd61;
  localparam logic [SIZE_BITS-1:0] RST_INIT   = SIZE_BITS'(4096);

  typedef enum logic {
    OP_ADD,   // a + b, over when the sum exceeds c
    OP_SUB    // a - b floored at zero
  } unit_op_t;

endpackage

### rtl/hdt_ram.sv
module hdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/hdt_size_unit.sv
module hdt_size_unit (
  input  hdt_pkg::unit_op_t              op,
  input  logic [hdt_pkg::SIZE_BITS-1:0]  a,
  input  logic [hdt_pkg::SIZE_BITS-1:0]  b,
  input  logic [hdt_pkg::SIZE_BITS-1:0]  c,
  output logic [hdt_pkg::SIZE_BITS-1:0]  res,
  output logic                           over
);

  logic [hdt_pkg::SIZE_BITS:0] sum;
  logic [hdt_pkg::SIZE_BITS:0] diff;

  always_comb begin
    sum  = {1'b0, a} + {1'b0, b};
    diff = {1'b0, a} - {1'b0, b};
    if (op == hdt_pkg::OP_ADD) begin
      res  = sum[hdt_pkg::SIZE_BITS-1:0];
      over = sum > {1'b0, c};
    end else begin
      // borrow out means the entry was larger than what is left
      res  = diff[hdt_pkg::SIZE_BITS] ? '0 : diff[hdt_pkg::SIZE_BITS-1:0];
      over = diff[hdt_pkg::SIZE_BITS];
    end
  end

endmodule

### rtl/hpack_dynamic_table_tracker.sv
// channel | direction | bus                         | moves
// in      | sink      | in_tvalid/tready/tdata/tuser | one request per transfer
// out     | source    | out_tvalid/tready/tdata      | one result per transfer
// cfg     | sink      | cfg_we/index/data            | one register write, no wait
//
// a request is decoded first; static resolve, acknowledge and an activate answered at
// decode then load a result, resize and an inserting activate evict oldest entries
// as needed (an activate may still be rejected after eviction), and a dynamic resolve
// walks the older links from the newest entry, paced by the shared add/subtract unit
// and the registered link reads; in_tready rises as the result loads, unless a result
// still waits in the output register, which holds the sequencer; rst_n is synchronous.
module hpack_dynamic_table_tracker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // entry_class, slot, entry_bytes, static_index, new_size
  input  logic [hdt_pkg::IN_TDATA_W-1:0]       in_tdata,
  // kind
  input  logic [hdt_pkg::KIND_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // status, found, table_index, entry_active, used_bytes, live_entries,
  // update_pending
  output logic [hdt_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                 cfg_we,
  input  logic [hdt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hdt_pkg::SIZE_BITS-1:0]        cfg_data
);

  localparam int SW = hdt_pkg::SIZE_BITS;
  localparam int LW = hdt_pkg::SLOT_W;
  localparam int PW = hdt_pkg::PTR_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_EVICT_CHK, S_EVICT_RD, S_LINK, S_WALK_CHK, S_WALK_RD, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [hdt_pkg::CNT_W-1:0]   cfg_slots_r, cfg_slots_nxt;
  logic [hdt_pkg::STATC_W-1:0] cfg_static_r, cfg_static_nxt;
  logic [SW-1:0]               cfg_init_r, cfg_init_nxt;

  hdt_pkg::kind_t              kind_r, kind_nxt;
  logic [hdt_pkg::CLASS_W-1:0] cls_r, cls_nxt;
  logic [LW-1:0]               slot_r, slot_nxt;
  logic [SW-1:0]               esize_r, esize_nxt;
  logic [hdt_pkg::SIDX_W-1:0]  sidx_r, sidx_nxt;
  logic [SW-1:0]               nsize_r, nsize_nxt;

  logic [hdt_pkg::SLOTS-1:0]   active_r, active_nxt;
  logic [PW-1:0]               newest_r, newest_nxt;
  logic [PW-1:0]               oldest_r, oldest_nxt;
  logic [SW-1:0]               cur_r, cur_nxt;
  logic [SW-1:0]               target_r, target_nxt;
  logic [SW-1:0]               signalled_r, signalled_nxt;
  logic [hdt_pkg::CNT_W-1:0]   total_r, total_nxt;
  logic                        pending_r, pending_nxt;

  hdt_pkg::status_t            status_r, status_nxt;
  logic                        found_r, found_nxt;
  logic [hdt_pkg::TIDX_W-1:0]  tindex_r, tindex_nxt;
  logic [LW-1:0]               walk_ptr_r, walk_ptr_nxt;
  logic [PW-1:0]               pos_r, pos_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [hdt_pkg::OUT_W-1:0]   out_data_r, out_data_nxt;

  hdt_pkg::unit_op_t u_op;
  logic [SW-1:0]     u_a, u_b, u_c, u_res;
  logic              u_over;

  logic          bytes_we, older_we, newer_we;
  logic [SW-1:0] bytes_rd;
  logic [LW-1:0] older_rd, newer_rd;

  logic slot_valid;
  logic entry_active;

  hdt_size_unit u_size (
    .op   (u_op),
    .a    (u_a),
    .b    (u_b),
    .c    (u_c),
    .res  (u_res),
    .over (u_over)
  );

  hdt_ram #(.WIDTH(SW), .DEPTH(hdt_pkg::SLOTS)) u_bytes_ram (
    .clk   (clk),
    .we    (bytes_we),
    .waddr (slot_r),
    .wdata (esize_r),
    .raddr (oldest_r[LW-1:0]),
    .rdata (bytes_rd)
  );

  // link towards the older neighbour, walked by resolve
  hdt_ram #(.WIDTH(LW), .DEPTH(hdt_pkg::SLOTS)) u_older_ram (
    .clk   (clk),
    .we    (older_we),
    .waddr (slot_r),
    .wdata (newest_r[LW-1:0]),
    .raddr (walk_ptr_r),
    .rdata (older_rd)
  );

  // link towards the newer neighbour, followed by eviction
  hdt_ram #(.WIDTH(LW), .DEPTH(hdt_pkg::SLOTS)) u_newer_ram (
    .clk   (clk),
    .we    (newer_we),
    .waddr (newest_r[LW-1:0]),
    .wdata (slot_r),
    .raddr (oldest_r[LW-1:0]),
    .rdata (newer_rd)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(hdt_pkg::OUT_TDATA_W - hdt_pkg::OUT_W){1'b0}}, out_data_r};

  assign slot_valid = ({1'b0, slot_r} < cfg_slots_r) && ({1'b0, slot_r} < PW'(hdt_pkg::SLOTS));
  assign entry_active = (cls_r == hdt_pkg::CLS_POLICY) && slot_valid && active_r[slot_r];

  always_comb begin
    state_nxt      = state_r;
    cfg_slots_nxt  = cfg_slots_r;
    cfg_static_nxt = cfg_static_r;
    cfg_init_nxt   = cfg_init_r;
    kind_nxt       = kind_r;
    cls_nxt        = cls_r;
    slot_nxt       = slot_r;
    esize_nxt      = esize_r;
    sidx_nxt       = sidx_r;
    nsize_nxt      = nsize_r;
    active_nxt     = active_r;
    newest_nxt     = newest_r;
    oldest_nxt     = oldest_r;
    cur_nxt        = cur_r;
    target_nxt     = target_r;
    signalled_nxt  = signalled_r;
    total_nxt      = total_r;
    pending_nxt    = pending_r;
    status_nxt     = status_r;
    found_nxt      = found_r;
    tindex_nxt     = tindex_r;
    walk_ptr_nxt   = walk_ptr_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    u_op = hdt_pkg::OP_ADD;
    u_a  = cur_r;
    u_b  = '0;
    u_c  = target_r;

    bytes_we = 1'b0;
    older_we = 1'b0;
    newer_we = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt   = hdt_pkg::kind_t'(in_tuser);
          cls_nxt    = in_tdata[1:0];
          slot_nxt   = in_tdata[7:2];
          esize_nxt  = in_tdata[27:8];
          sidx_nxt   = in_tdata[35:28];
          nsize_nxt  = in_tdata[55:36];
          status_nxt = hdt_pkg::ST_OK;
          found_nxt  = 1'b0;
          tindex_nxt = '0;
          state_nxt  = S_DECODE;
        end
      end

      S_DECODE: begin
        // unit checks the entry byte count against the target
        u_a = esize_r;
        u_b = '0;
        u_c = target_r;
        unique case (kind_r)
          hdt_pkg::KIND_ACTIVATE: begin
            state_nxt = S_DONE;
            if (cls_r == hdt_pkg::CLS_STATIC) begin
              status_nxt = hdt_pkg::ST_STATIC;
            end else if (!slot_valid) begin
              status_nxt = hdt_pkg::ST_INVALID;
            end else if (active_r[slot_r]) begin
              status_nxt = hdt_pkg::ST_ALREADY;
            end else if (cls_r != hdt_pkg::CLS_POLICY || u_over || target_r == '0) begin
              status_nxt = hdt_pkg::ST_REJECT;
            end else begin
              state_nxt = S_EVICT_CHK;
            end
          end
          hdt_pkg::KIND_RESOLVE: begin
            state_nxt = S_DONE;
            if (cls_r == hdt_pkg::CLS_STATIC) begin
              tindex_nxt = {1'b0, sidx_r};
              found_nxt  = (sidx_r != '0);
            end else if (entry_active) begin
              walk_ptr_nxt = newest_r[LW-1:0];
              pos_nxt      = PW'(1);
              state_nxt    = S_WALK_CHK;
            end
          end
          hdt_pkg::KIND_RESIZE: begin
            target_nxt  = nsize_r;
            pending_nxt = (nsize_r != signalled_r);
            state_nxt   = S_EVICT_CHK;
          end
          hdt_pkg::KIND_ACK: begin
            signalled_nxt = target_r;
            pending_nxt   = 1'b0;
            state_nxt     = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_EVICT_CHK: begin
        u_a = cur_r;
        u_b = (kind_r == hdt_pkg::KIND_ACTIVATE) ? esize_r : '0;
        u_c = target_r;
        if (!u_over) begin
          state_nxt = (kind_r == hdt_pkg::KIND_ACTIVATE) ? S_LINK : S_DONE;
        end else if (oldest_r == hdt_pkg::NONE_PTR) begin
          if (kind_r == hdt_pkg::KIND_ACTIVATE) begin
            status_nxt = hdt_pkg::ST_REJECT;
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_EVICT_RD;
        end
      end

      S_EVICT_RD: begin
        u_op    = hdt_pkg::OP_SUB;
        u_a     = cur_r;
        u_b     = bytes_rd;
        cur_nxt = u_res;
        // a single entry left has no newer neighbour
        if (oldest_r == newest_r) begin
          newest_nxt = hdt_pkg::NONE_PTR;
          oldest_nxt = hdt_pkg::NONE_PTR;
        end else begin
          oldest_nxt = {1'b0, newer_rd};
        end
        active_nxt[oldest_r[LW-1:0]] = 1'b0;
        if (total_r != '0) begin
          total_nxt = total_r - 1'b1;
        end
        state_nxt = S_EVICT_CHK;
      end

      S_LINK: begin
        u_op     = hdt_pkg::OP_ADD;
        u_a      = cur_r;
        u_b      = esize_r;
        cur_nxt  = u_res;
        bytes_we = 1'b1;
        older_we = 1'b1;
        if (newest_r != hdt_pkg::NONE_PTR) begin
          newer_we = 1'b1;
        end else begin
          oldest_nxt = {1'b0, slot_r};
        end
        newest_nxt         = {1'b0, slot_r};
        active_nxt[slot_r] = 1'b1;
        total_nxt          = total_r + 1'b1;
        status_nxt         = hdt_pkg::ST_OK;
        state_nxt          = S_DONE;
      end

      S_WALK_CHK: begin
        u_op = hdt_pkg::OP_ADD;
        u_a  = SW'(cfg_static_r);
        u_b  = SW'(pos_r);
        if (walk_ptr_r == slot_r) begin
          tindex_nxt = u_res[hdt_pkg::TIDX_W-1:0];
          found_nxt  = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end

      S_WALK_RD: begin
        walk_ptr_nxt = older_rd;
        pos_nxt      = pos_r + 1'b1;
        state_nxt    = S_WALK_CHK;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {pending_r, total_r, cur_r, entry_active, tindex_r, found_r,
                           status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // a write to any of the three registers re-initialises the table
    if (cfg_we && (cfg_index == hdt_pkg::CFG_SLOTS || cfg_index == hdt_pkg::CFG_STATIC ||
                   cfg_index == hdt_pkg::CFG_INIT)) begin
      if (cfg_index == hdt_pkg::CFG_SLOTS) begin
        cfg_slots_nxt = cfg_data[hdt_pkg::CNT_W-1:0];
      end
      if (cfg_index == hdt_pkg::CFG_STATIC) begin
        cfg_static_nxt = cfg_data[hdt_pkg::STATC_W-1:0];
      end
      if (cfg_index == hdt_pkg::CFG_INIT) begin
        cfg_init_nxt = cfg_data;
      end
      active_nxt    = '0;
      newest_nxt    = hdt_pkg::NONE_PTR;
      oldest_nxt    = hdt_pkg::NONE_PTR;
      cur_nxt       = '0;
      target_nxt    = (cfg_index == hdt_pkg::CFG_INIT) ? cfg_data : cfg_init_r;
      signalled_nxt = (cfg_index == hdt_pkg::CFG_INIT) ? cfg_data : cfg_init_r;
      total_nxt     = '0;
      pending_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_slots_r  <= hdt_pkg::RST_SLOTS;
      cfg_static_r <= hdt_pkg::RST_STATIC;
      cfg_init_r   <= hdt_pkg::RST_INIT;
      active_r     <= '0;
      newest_r     <= hdt_pkg::NONE_PTR;
      oldest_r     <= hdt_pkg::NONE_PTR;
      cur_r        <= '0;
      target_r     <= hdt_pkg::RST_INIT;
      signalled_r  <= hdt_pkg::RST_INIT;
      total_r      <= '0;
      pending_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cfg_slots_r  <= cfg_slots_nxt;
      cfg_static_r <= cfg_static_nxt;
      cfg_init_r   <= cfg_init_nxt;
      active_r     <= active_nxt;
      newest_r     <= newest_nxt;
      oldest_r     <= oldest_nxt;
      cur_r        <= cur_nxt;
      target_r     <= target_nxt;
      signalled_r  <= signalled_nxt;
      total_r      <= total_nxt;
      pending_r    <= pending_nxt;
      out_valid_r  <= out_valid_nxt;
      kind_r       <= kind_nxt;
      cls_r        <= cls_nxt;
      slot_r       <= slot_nxt;
      esize_r      <= esize_nxt;
      sidx_r       <= sidx_nxt;
      nsize_r      <= nsize_nxt;
      status_r     <= status_nxt;
      found_r      <= found_nxt;
      tindex_r     <= tindex_nxt;
      walk_ptr_r   <= walk_ptr_nxt;
      pos_r        <= pos_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

endmodule
